/* rtl/gosd_pkg.sv */
// Shared types and constants of the grain onset span detector.
package gosd_pkg;

   // Fixed field widths
   localparam int SampleBits = 16;
   localparam int MagBits    = SampleBits + 1;
   localparam int FrameBits  = 32;
   localparam int QuietBits  = 32;
   localparam int GateBits   = 10;
   localparam int HoleBits   = 21;
   localparam int SpliceBits = 16;
   localparam int ChanBits   = 2;
   localparam int CmdBits    = 2;
   localparam int KindBits   = 2;
   localparam int CsrIdxBits = 2;
   localparam int CsrBits    = 21;
   localparam int SpanBits   = FrameBits + 3;
   localparam int RspDepth   = 4;
   localparam int RspPtrBits = 2;
   localparam int RspCntBits = 3;

   // Input commands
   localparam logic [CmdBits-1:0] CMD_PEAK   = 2'd0;
   localparam logic [CmdBits-1:0] CMD_DETECT = 2'd1;
   localparam logic [CmdBits-1:0] CMD_END    = 2'd2;

   // Result kinds
   localparam logic [KindBits-1:0] KIND_SPAN      = 2'd0;
   localparam logic [KindBits-1:0] KIND_DONE_OK   = 2'd1;
   localparam logic [KindBits-1:0] KIND_DONE_FEW  = 2'd2;

   // Configuration register indexes
   localparam logic [CsrIdxBits-1:0] REG_GATE_FRAC   = 2'd0;
   localparam logic [CsrIdxBits-1:0] REG_MIN_HOLE    = 2'd1;
   localparam logic [CsrIdxBits-1:0] REG_HALF_SPLICE = 2'd2;
   localparam logic [CsrIdxBits-1:0] REG_CHANNELS    = 2'd3;

   // One result item
   typedef struct packed {
      logic [KindBits-1:0]  kind;
      logic [FrameBits-1:0] span_length;
      logic [FrameBits-1:0] span_start;
      logic                 is_last;
   } rsp_item_type;

   // Magnitude of a two's complement sample, most negative value held exactly
   function automatic logic [MagBits-1:0] sample_mag(input logic [SampleBits-1:0] s);
      logic [MagBits-1:0] ext;
      ext = {s[SampleBits-1], s};
      return s[SampleBits-1] ? MagBits'(~ext + MagBits'(1)) : ext;
   endfunction

endpackage

/* rtl/grain_onset_span_detector_top.sv */
// Each item is registered at the input; when the registered item fires, its results are
// written into the output queue, and rsp_tvalid is high while the queue is not empty.
// Throughput: one item per cycle; the end command writes up to two results together
// through the four-entry output queue, which stalls the input when it holds three or more.
// Reset: synchronous, active high; registers return to their defaults, detector
// state and output queue are cleared. The end command also clears detector state.
module grain_onset_span_detector_top
   import gosd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port
   input  logic                  csr_wr_en,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [CsrBits-1:0]    csr_wdata,
   // Input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // sample_a[15:0], sample_b[31:16]
   input  logic [CmdBits-1:0]    req_tuser,  // cmd[1:0]
   // Result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,  // span_start[31:0], span_length[63:32]
   output logic [KindBits-1:0]   rsp_tuser,  // kind[1:0]
   output logic                  rsp_tlast   // is_last
);

   // Configuration registers
   logic [GateBits-1:0]   gate_frac_ff;
   logic [HoleBits-1:0]   min_hole_ff;
   logic [SpliceBits-1:0] half_splice_ff;
   logic [ChanBits-1:0]   channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_frac_ff   <= GateBits'(307);
         min_hole_ff    <= HoleBits'(1536);
         half_splice_ff <= SpliceBits'(360);
         channels_ff    <= ChanBits'(2);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GATE_FRAC:   gate_frac_ff   <= csr_wdata[GateBits-1:0];
            REG_MIN_HOLE:    min_hole_ff    <= csr_wdata[HoleBits-1:0];
            REG_HALF_SPLICE: half_splice_ff <= csr_wdata[SpliceBits-1:0];
            REG_CHANNELS:    channels_ff    <= csr_wdata[ChanBits-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic                  in_valid_ff;
   logic [CmdBits-1:0]    in_cmd_ff;
   logic [SampleBits-1:0] in_a_ff;
   logic [SampleBits-1:0] in_b_ff;
   logic                  fire;
   logic [RspCntBits-1:0] count_ff;

   assign fire       = in_valid_ff && (count_ff <= RspCntBits'(RspDepth - 2));
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_a_ff   <= req_tdata[SampleBits-1:0];
         in_b_ff   <= req_tdata[2*SampleBits-1:SampleBits];
      end
   end

   // Detector state
   logic [MagBits-1:0]   peak_ff,   peak_in;
   logic [FrameBits-1:0] frame_ff,  frame_in;
   logic [QuietBits-1:0] quiet_ff,  quiet_in;
   logic                 seen_ff,   seen_in;
   logic [FrameBits-1:0] onset_ff,  onset_in;
   logic [1:0]           kept_ff,   kept_in;

   // Per-item datapath
   logic [MagBits-1:0]            mag_a, mag_b;
   logic                          two_lanes;
   logic [GateBits+MagBits-1:0]   gate_prod;
   logic [MagBits-1:0]            gate;
   logic                          in_grain;
   logic [HoleBits-1:0]           hole;
   logic                          hole_met;
   logic signed [SpanBits-1:0]    start_raw, span_start, det_end, span_end, span_diff;
   logic                          span_keep;
   logic [1:0]                    push_n;
   rsp_item_type                  push0, push1;
   rsp_item_type                  span_item, done_item;
   logic [1:0]                    kept_inc;

   assign mag_a     = sample_mag(in_a_ff);
   assign mag_b     = sample_mag(in_b_ff);
   assign two_lanes = channels_ff[1];
   assign gate_prod = gate_frac_ff * peak_ff;
   assign gate      = gate_prod[GateBits+MagBits-1:GateBits];
   assign in_grain  = (peak_ff != '0) && ((mag_a > gate) || (two_lanes && (mag_b > gate)));
   assign hole      = (min_hole_ff == '0) ? HoleBits'(1) : min_hole_ff;
   assign hole_met  = quiet_ff >= QuietBits'(hole);

   // Span bounds: start clamps at zero, end is the next onset less the splice or
   // the source length on the end command
   assign start_raw  = $signed({3'b000, onset_ff}) - $signed(SpanBits'(half_splice_ff));
   assign span_start = start_raw[SpanBits-1] ? '0 : start_raw;
   assign det_end    = $signed({3'b000, frame_ff}) - $signed(SpanBits'(half_splice_ff));
   assign span_end   = (in_cmd_ff == CMD_END) ? $signed({3'b000, frame_ff}) : det_end;
   assign span_diff  = span_end - span_start;
   assign span_keep  = !span_diff[SpanBits-1] && (span_diff[SpanBits-2:1] != '0);
   assign kept_inc   = (kept_ff == 2'd2) ? kept_ff : kept_ff + 2'd1;

   always_comb begin
      span_item.kind        = KIND_SPAN;
      span_item.span_start  = span_start[FrameBits-1:0];
      span_item.span_length = span_diff[FrameBits-1:0];
      span_item.is_last     = 1'b1;
      done_item.kind        = KIND_DONE_FEW;
      done_item.span_start  = '0;
      done_item.span_length = '0;
      done_item.is_last     = 1'b1;
   end

   // Next state and result pushes
   always_comb begin
      peak_in  = peak_ff;
      frame_in = frame_ff;
      quiet_in = quiet_ff;
      seen_in  = seen_ff;
      onset_in = onset_ff;
      kept_in  = kept_ff;
      push_n   = 2'd0;
      push0    = span_item;
      push1    = done_item;
      if (fire) begin
         unique case (in_cmd_ff)
            CMD_PEAK: begin
               if (mag_a > peak_in) begin
                  peak_in = mag_a;
               end
               if (two_lanes && (mag_b > peak_in)) begin
                  peak_in = mag_b;
               end
            end
            CMD_DETECT: begin
               if (in_grain) begin
                  if (!seen_ff) begin
                     seen_in  = 1'b1;
                     onset_in = frame_ff;
                  end else if (hole_met) begin
                     onset_in = frame_ff;
                     if (span_keep) begin
                        push_n  = 2'd1;
                        kept_in = kept_inc;
                     end
                  end
                  quiet_in = '0;
               end else if (seen_ff && (quiet_ff != '1)) begin
                  quiet_in = quiet_ff + QuietBits'(1);
               end
               if (frame_ff != '1) begin
                  frame_in = frame_ff + FrameBits'(1);
               end
            end
            CMD_END: begin
               // Emit the final span if long enough, then the done status
               if (seen_ff && span_keep) begin
                  push0.is_last = 1'b0;
                  push1.kind    = (kept_inc == 2'd2) ? KIND_DONE_OK : KIND_DONE_FEW;
                  push_n        = 2'd2;
               end else begin
                  push0      = done_item;
                  push0.kind = (kept_ff == 2'd2) ? KIND_DONE_OK : KIND_DONE_FEW;
                  push_n     = 2'd1;
               end
               peak_in  = '0;
               frame_in = '0;
               quiet_in = '0;
               seen_in  = 1'b0;
               onset_in = '0;
               kept_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         frame_ff <= '0;
         quiet_ff <= '0;
         seen_ff  <= 1'b0;
         onset_ff <= '0;
         kept_ff  <= '0;
      end else begin
         peak_ff  <= peak_in;
         frame_ff <= frame_in;
         quiet_ff <= quiet_in;
         seen_ff  <= seen_in;
         onset_ff <= onset_in;
         kept_ff  <= kept_in;
      end
   end

   // Output queue: up to two writes and one read per cycle
   rsp_item_type          queue_ff [RspDepth];
   logic [RspPtrBits-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RspPtrBits-1:0] wr_ptr_next;
   logic                  pop;
   rsp_item_type          head;

   assign wr_ptr_next = wr_ptr_ff + RspPtrBits'(1);
   assign head        = queue_ff[rd_ptr_ff];
   assign rsp_tvalid  = (count_ff != '0);
   assign pop         = rsp_tvalid && rsp_tready;
   assign rsp_tdata   = {head.span_length, head.span_start};
   assign rsp_tuser   = head.kind;
   assign rsp_tlast   = head.is_last;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RspPtrBits'(push_n);
         rd_ptr_ff <= rd_ptr_ff + RspPtrBits'(pop);
         count_ff  <= count_ff + RspCntBits'(push_n) - RspCntBits'(pop);
      end
   end

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RspCntBits'(RspDepth))
      else $error("output queue over capacity");

   a_double_push_end: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (fire && (in_cmd_ff == CMD_END)))
      else $error("two results pushed by a non-end item");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_cmd_ff == CMD_END)) |=> (!seen_ff && (kept_ff == 2'd0) && (peak_ff == '0)))
      else $error("end command did not clear detector state");

   a_kept_sat: assert property (@(posedge clock) disable iff (reset)
      kept_ff != 2'd3)
      else $error("kept grain count beyond saturation");

endmodule
